[rtl/core/derb_pkg.sv]
package derb_pkg;

  // fixed field widths
  localparam int unsigned FuncWidth      = 3;
  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned SlotIndexWidth = 4;
  localparam int unsigned HeldCountWidth = 5;
  localparam int unsigned SizeWidth      = 5;

  // parameter defaults
  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultWordWidth = 32;

  // queue depths
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned ResQueueDepth = 4;

  // operation codes on the func field
  localparam logic [FuncWidth-1:0] FuncPushBack  = 3'd0;
  localparam logic [FuncWidth-1:0] FuncPushFront = 3'd1;
  localparam logic [FuncWidth-1:0] FuncPopBack   = 3'd2;
  localparam logic [FuncWidth-1:0] FuncPopFront  = 3'd3;
  localparam logic [FuncWidth-1:0] FuncReadSlot  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [SlotIndexWidth-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [ValueWidth-1:0]     read_value;
    logic [HeldCountWidth-1:0] held_count;
    logic                      dropped;
    logic                      fault;
  } res_t;

endpackage

[rtl/core/derb_ram.sv]
module derb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/derb_fifo.sv]
module derb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [WIDTH-1:0]           wr_data_i,
  output logic                       full_o,
  input  logic                       rd_en_i,
  output logic [WIDTH-1:0]           rd_data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/core/derb_front.sv]
module derb_front import derb_pkg::*; #(
  parameter int unsigned WORD_WIDTH = DefaultWordWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [FuncWidth-1:0]        func_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [SlotIndexWidth-1:0]   slot_index_i,
  output logic                        full_o,
  input  logic                        busy_i,
  input  logic                        cmd_pop_i,
  output logic                        cmd_valid_o,
  output cmd_t                        cmd_o,
  output logic [WORD_WIDTH-1:0]       cmd_word_o
);

  localparam int unsigned EntryW = WORD_WIDTH + $bits(cmd_t);

  cmd_t                  cmd_in;
  logic [WORD_WIDTH-1:0] word_in;
  logic [EntryW-1:0]     entry_out;
  logic                  q_full, q_empty;

  // classify the operation code
  always_comb begin
    cmd_in.slot_index = slot_index_i;
    unique case (func_i)
      FuncPushBack:  cmd_in.op = OP_PUSH_BACK;
      FuncPushFront: cmd_in.op = OP_PUSH_FRONT;
      FuncPopBack:   cmd_in.op = OP_POP_BACK;
      FuncPopFront:  cmd_in.op = OP_POP_FRONT;
      FuncReadSlot:  cmd_in.op = OP_READ;
      default:       cmd_in.op = OP_NONE;
    endcase
  end

  // fit the pushed word to the stored width
  if (WORD_WIDTH < ValueWidth) begin : g_narrow
    assign word_in = value_i[WORD_WIDTH-1:0];
  end else if (WORD_WIDTH == ValueWidth) begin : g_same
    assign word_in = value_i;
  end else begin : g_wide
    assign word_in = {{(WORD_WIDTH - ValueWidth){1'b0}}, value_i};
  end

  derb_fifo #(
    .WIDTH (EntryW),
    .DEPTH (CmdQueueDepth)
  ) u_cmd_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i && !full_o),
    .wr_data_i ({word_in, cmd_in}),
    .full_o    (q_full),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (entry_out),
    .empty_o   (q_empty),
    .count_o   ()
  );

  assign full_o      = q_full || busy_i;
  assign cmd_valid_o = !q_empty;
  assign {cmd_word_o, cmd_o} = entry_out;

endmodule

[rtl/core/derb_back.sv]
module derb_back import derb_pkg::*; #(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned WORD_WIDTH = DefaultWordWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SizeWidth-1:0]  cfg_size_i,
  output logic                  busy_o,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  input  logic [WORD_WIDTH-1:0] cmd_word_i,
  output logic                  cmd_pop_o,
  input  logic                  res_pop_i,
  output logic                  res_empty_o,
  output res_t                  res_o
);

  localparam int unsigned AddrW   = $clog2(DEPTH);
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned ResCntW = $clog2(ResQueueDepth + 1);

  function automatic logic [AddrW-1:0] step_up(input logic [AddrW-1:0] p,
                                               input logic [CntW-1:0]  s);
    logic [CntW-1:0] n;
    n = CntW'(p) + CntW'(1);
    return (n >= s) ? '0 : AddrW'(n);
  endfunction

  function automatic logic [AddrW-1:0] step_down(input logic [AddrW-1:0] p,
                                                 input logic [CntW-1:0]  s);
    return (p == '0) ? AddrW'(s - CntW'(1)) : p - AddrW'(1);
  endfunction

  logic [CntW-1:0]       size_q, size_cfg;
  logic [AddrW-1:0]      front_q, front_d, back_q, back_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  clear_q;
  logic [AddrW-1:0]      clr_addr_q;
  logic                  inflight_q, rd_ok_q, dropped_q, fault_q;
  logic [HeldCountWidth-1:0] hc_q;

  logic                  issue, credit_ok;
  logic [ResCntW-1:0]    res_count;
  logic [ResCntW:0]      res_used;
  logic [AddrW-1:0]      front_up, front_dn, back_up, back_dn;
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
  logic                  dropped, fault, rd_ok;
  logic [ValueWidth-1:0] rd_ext;
  res_t                  res_in;

  // clamp a written size into 1..DEPTH
  always_comb begin
    if (cfg_size_i == '0) begin
      size_cfg = CntW'(1);
    end else if (cfg_size_i > DEPTH) begin
      size_cfg = CntW'(DEPTH);
    end else begin
      size_cfg = CntW'(cfg_size_i);
    end
  end

  // credit check keeps the result queue from overflowing
  assign res_used  = (ResCntW + 1)'(res_count) + (ResCntW + 1)'(inflight_q);
  assign credit_ok = res_used < (ResCntW + 1)'(ResQueueDepth);
  assign issue     = cmd_valid_i && !clear_q && !cfg_we_i && credit_ok;
  assign cmd_pop_o = issue;
  assign busy_o    = clear_q;

  assign front_up = step_up(front_q, size_q);
  assign front_dn = step_down(front_q, size_q);
  assign back_up  = step_up(back_q, size_q);
  assign back_dn  = step_down(back_q, size_q);
  assign ram_raddr = AddrW'(cmd_i.slot_index);

  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = front_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    dropped   = 1'b0;
    fault     = 1'b0;
    rd_ok     = 1'b0;
    if (clear_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end
    if (issue) begin
      unique case (cmd_i.op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          ram_we    = 1'b1;
          ram_wdata = cmd_word_i;
          if (count_q == '0) begin
            // empty ring: both ends land on the front slot
            back_d    = front_q;
            ram_waddr = front_q;
            count_d   = CntW'(1);
          end else if (cmd_i.op == OP_PUSH_BACK) begin
            back_d    = back_up;
            ram_waddr = back_up;
            if (back_up == front_q) begin
              front_d = front_up;
              dropped = 1'b1;
            end else begin
              count_d = count_q + CntW'(1);
            end
          end else begin
            front_d   = front_dn;
            ram_waddr = front_dn;
            if (front_dn == back_q) begin
              back_d  = back_dn;
              dropped = 1'b1;
            end else begin
              count_d = count_q + CntW'(1);
            end
          end
        end
        OP_POP_BACK: begin
          if (count_q == '0) begin
            fault = 1'b1;
          end else begin
            count_d   = count_q - CntW'(1);
            ram_we    = 1'b1;
            ram_waddr = back_q;
            back_d    = back_dn;
          end
        end
        OP_POP_FRONT: begin
          if (count_q == '0) begin
            fault = 1'b1;
          end else begin
            count_d   = count_q - CntW'(1);
            ram_we    = 1'b1;
            ram_waddr = front_q;
            front_d   = front_up;
          end
        end
        OP_READ: begin
          if (cmd_i.slot_index >= size_q) begin
            fault = 1'b1;
          end else begin
            ram_re = 1'b1;
            rd_ok  = 1'b1;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q     <= CntW'(DEPTH);
      front_q    <= '0;
      back_q     <= '0;
      count_q    <= '0;
      clear_q    <= 1'b1;
      clr_addr_q <= '0;
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= issue;
      if (cfg_we_i) begin
        size_q     <= size_cfg;
        front_q    <= '0;
        back_q     <= '0;
        count_q    <= '0;
        clear_q    <= 1'b1;
        clr_addr_q <= '0;
      end else begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
        if (clear_q) begin
          if (clr_addr_q == AddrW'(DEPTH - 1)) begin
            clear_q <= 1'b0;
          end else begin
            clr_addr_q <= clr_addr_q + AddrW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q   <= rd_ok;
    dropped_q <= dropped;
    fault_q   <= fault;
    hc_q      <= HeldCountWidth'(count_d);
  end

  derb_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // stored word back to the signed output width
  if (WORD_WIDTH < ValueWidth) begin : g_sext
    assign rd_ext = {{(ValueWidth - WORD_WIDTH){ram_rdata[WORD_WIDTH-1]}}, ram_rdata};
  end else begin : g_trunc
    assign rd_ext = ram_rdata[ValueWidth-1:0];
  end

  always_comb begin
    res_in.read_value = rd_ok_q ? rd_ext : '0;
    res_in.held_count = hc_q;
    res_in.dropped    = dropped_q;
    res_in.fault      = fault_q;
  end

  derb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ResQueueDepth)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (inflight_q),
    .wr_data_i (res_in),
    .full_o    (),
    .rd_en_i   (res_pop_i),
    .rd_data_o (res_o),
    .empty_o   (res_empty_o),
    .count_o   (res_count)
  );

endmodule

[rtl/core/double_ended_ring_buffer.sv]
// each result is registered in the back end and then buffered in the result queue
// throughput: one transaction per cycle while no clearing pass runs and the result queue
//   has room; slot memory writes and reads use separate ports
// reset (and every size write) empties the ring and runs a clearing pass that zeroes
//   all DEPTH slots; full stays high during that pass, config writes are still taken
module double_ended_ring_buffer import derb_pkg::*; #(
  parameter int unsigned DEPTH      = DefaultDepth,
  parameter int unsigned WORD_WIDTH = DefaultWordWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // size register write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [SizeWidth-1:0]         size_in_use_i,
  // item queue side
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [FuncWidth-1:0]         func_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [SlotIndexWidth-1:0]    slot_index_i,
  // result queue side
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic signed [ValueWidth-1:0] read_value_o,
  output logic [HeldCountWidth-1:0]    held_count_o,
  output logic                         dropped_o,
  output logic                         fault_o
);

  // front end to back end
  logic                  busy;
  logic                  cmd_valid, cmd_pop;
  cmd_t                  cmd;
  logic [WORD_WIDTH-1:0] cmd_word;
  res_t                  res;

  // the size register is always writable; a write restarts the clearing pass
  assign cfg_ready_o = 1'b1;

  // front end: decodes the op code, fits the word, buffers commands
  derb_front #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .func_i       (func_i),
    .value_i      (value_i),
    .slot_index_i (slot_index_i),
    .full_o       (full_o),
    .busy_i       (busy),
    .cmd_pop_i    (cmd_pop),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_word_o   (cmd_word)
  );

  // back end: owns pointers, count, slot memory and the result queue
  derb_back #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_size_i  (size_in_use_i),
    .busy_o      (busy),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_word_i  (cmd_word),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (pop_i),
    .res_empty_o (empty_o),
    .res_o       (res)
  );

  // unpack the oldest waiting result onto the ports
  assign read_value_o = res.read_value;
  assign held_count_o = res.held_count;
  assign dropped_o    = res.dropped;
  assign fault_o      = res.fault;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import derb_pkg::*;

  // codes the package leaves unnamed: the block must ignore them
  localparam logic [FuncWidth-1:0] FuncFirstUnused = FuncReadSlot + 3'd1;
  localparam logic [FuncWidth-1:0] FuncLastUnused  = '1;

  localparam int NumRows    = 27;
  localparam int NumBlocks  = 12;
  localparam int BlockItems = 80;
  localparam int CycleLimit = 200000;

  // one row of the directed table: either a size write or an item
  typedef struct packed {
    logic                      is_cfg;
    logic [SizeWidth-1:0]      cfg_size;
    logic [FuncWidth-1:0]      func;
    logic [ValueWidth-1:0]     value;
    logic [SlotIndexWidth-1:0] slot;
    logic                      typed;
    res_t                      want;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [SizeWidth-1:0]         size_in_use_i = '0;
  logic                         push_i = 1'b0;
  logic                         full_o;
  logic [FuncWidth-1:0]         func_i = '0;
  logic signed [ValueWidth-1:0] value_i = '0;
  logic [SlotIndexWidth-1:0]    slot_index_i = '0;
  logic                         empty_o;
  logic                         pop_i = 1'b0;
  logic signed [ValueWidth-1:0] read_value_o;
  logic [HeldCountWidth-1:0]    held_count_o;
  logic                         dropped_o;
  logic                         fault_o;

  double_ended_ring_buffer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .size_in_use_i (size_in_use_i),
    .push_i        (push_i),
    .full_o        (full_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .slot_index_i  (slot_index_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .read_value_o  (read_value_o),
    .held_count_o  (held_count_o),
    .dropped_o     (dropped_o),
    .fault_o       (fault_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the ring
  logic [ValueWidth-1:0]     ring_mem [DefaultDepth];
  logic [SlotIndexWidth-1:0] front_idx;
  logic [SlotIndexWidth-1:0] back_idx;
  logic [HeldCountWidth-1:0] fill_count;
  logic [SizeWidth-1:0]      ring_size;

  res_t expected_results [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  // append one expected result at the tail of the scoreboard
  function automatic void expect_add(res_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic void ring_clear();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    front_idx  = '0;
    back_idx   = '0;
    fill_count = '0;
  endfunction

  // out-of-range sizes are clamped, and any write empties the ring
  function automatic void size_apply(logic [SizeWidth-1:0] v);
    if (v == 0) ring_size = 5'd1;
    else if (v > DefaultDepth) ring_size = SizeWidth'(DefaultDepth);
    else ring_size = v;
    ring_clear();
  endfunction

  function automatic logic [SlotIndexWidth-1:0] ring_next(logic [SlotIndexWidth-1:0] p);
    logic [SizeWidth-1:0] n = {1'b0, p} + 5'd1;
    return (n >= ring_size) ? '0 : n[SlotIndexWidth-1:0];
  endfunction

  function automatic logic [SlotIndexWidth-1:0] ring_prev(logic [SlotIndexWidth-1:0] p);
    logic [SizeWidth-1:0] last = ring_size - 5'd1;
    return (p == 0) ? last[SlotIndexWidth-1:0] : p - 4'd1;
  endfunction

  // applies one operation to the shadow ring and returns its result
  function automatic res_t ring_apply(logic [FuncWidth-1:0] op, logic [ValueWidth-1:0] word,
                                      logic [SlotIndexWidth-1:0] slot);
    res_t r = '0;
    if ({1'b0, front_idx} >= ring_size) front_idx = '0;
    if ({1'b0, back_idx} >= ring_size) back_idx = '0;
    case (op)
      FuncPushBack, FuncPushFront: begin
        if (fill_count == 0) begin
          // push onto an empty ring lands on the front slot, both ends there
          back_idx = front_idx;
          ring_mem[front_idx] = word;
          fill_count = 5'd1;
        end else if (op == FuncPushBack) begin
          back_idx = ring_next(back_idx);
          if (back_idx == front_idx) begin
            front_idx = ring_next(front_idx);
            r.dropped = 1'b1;
          end else begin
            fill_count++;
          end
          ring_mem[back_idx] = word;
        end else begin
          front_idx = ring_prev(front_idx);
          if (front_idx == back_idx) begin
            back_idx = ring_prev(back_idx);
            r.dropped = 1'b1;
          end else begin
            fill_count++;
          end
          ring_mem[front_idx] = word;
        end
      end
      FuncPopBack: begin
        if (fill_count == 0) begin
          r.fault = 1'b1;
        end else begin
          fill_count--;
          ring_mem[back_idx] = '0;
          back_idx = ring_prev(back_idx);
        end
      end
      FuncPopFront: begin
        if (fill_count == 0) begin
          r.fault = 1'b1;
        end else begin
          fill_count--;
          ring_mem[front_idx] = '0;
          front_idx = ring_next(front_idx);
        end
      end
      FuncReadSlot: begin
        if ({1'b0, slot} >= ring_size) r.fault = 1'b1;
        else r.read_value = ring_mem[slot];
      end
      default: ;
    endcase
    r.held_count = fill_count;
    return r;
  endfunction

  // directed table: want is used only where typed is set
  stim_row_t directed_rows [NumRows];

  initial begin
    directed_rows = '{
      // pops on an empty ring fault and leave the count alone; a read of slot 15 returns zero
      '{1'b0, 5'd0, FuncPopBack, 32'd0, 4'd0, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b1}},
      '{1'b0, 5'd0, FuncPopFront, 32'd0, 4'd0, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b1}},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd15, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
      // unused codes do nothing; then pushes, reads and pops on the full-size ring
      '{1'b0, 5'd0, FuncFirstUnused, 32'hffffffff, 4'd15, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
      '{1'b0, 5'd0, FuncLastUnused, 32'h12345678, 4'd0, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
      '{1'b0, 5'd0, FuncPushBack, 32'h7fffffff, 4'd0, 1'b1, '{32'd0, 5'd1, 1'b0, 1'b0}},
      '{1'b0, 5'd0, FuncPushFront, 32'h80000000, 4'd0, 1'b1, '{32'd0, 5'd2, 1'b0, 1'b0}},
      '{1'b0, 5'd0, FuncPushBack, 32'hffffffff, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd15, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPopBack, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPopFront, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPopFront, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPopBack, 32'd0, 4'd0, 1'b0, '0},
      // one-slot ring: every push after the first overwrites
      '{1'b1, 5'd1, FuncPushBack, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPushBack, 32'd5, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPushBack, 32'd6, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPushFront, 32'd7, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd0, 1'b0, '0},
      // read beyond the size in use
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd1, 1'b1, '{32'd0, 5'd1, 1'b0, 1'b1}},
      // size zero is taken as one and the ring comes back empty
      '{1'b1, 5'd0, FuncPushBack, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd0, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
      // oversize is taken as the full depth
      '{1'b1, 5'd31, FuncPushBack, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd15, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
      '{1'b0, 5'd0, FuncPushFront, 32'h55aa55aa, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncPopFront, 32'd0, 4'd0, 1'b0, '0},
      '{1'b0, 5'd0, FuncReadSlot, 32'd0, 4'd0, 1'b0, '0}
    };
  end

  // lower push and wait until every expected result has been popped
  task automatic drain_results();
    @(negedge clk_i);
    push_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // size writes happen only with the ring idle
  task automatic size_write(logic [SizeWidth-1:0] v);
    drain_results();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i   = 1'b1;
    size_in_use_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_apply(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one item until it is taken; push stays high afterward
  task automatic send_item(logic [FuncWidth-1:0] op, logic [ValueWidth-1:0] word,
                           logic [SlotIndexWidth-1:0] slot, logic typed, res_t want);
    bit   taken = 1'b0;
    res_t pred;
    while (!taken) begin
      @(negedge clk_i);
      push_i       = ($urandom_range(0, 99) >= send_idle_pct);
      func_i       = op;
      value_i      = word;
      slot_index_i = slot;
      @(posedge clk_i);
      taken = push_i && !full_o;
    end
    pred = ring_apply(op, word, slot);
    expect_add(typed ? want : pred);
  endtask

  // result side: random pop, compare each popped transaction
  always @(negedge clk_i) begin
    pop_i = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && pop_i && !empty_o) begin
      got = '{read_value_o, held_count_o, dropped_o, fault_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result rv=%h cnt=%0d drop=%0b fault=%0b",
                   got.read_value, got.held_count, got.dropped, got.fault);
      end else begin
        want = expected_results.pop_front();
        if (got.read_value !== want.read_value || got.held_count !== want.held_count ||
            got.dropped !== want.dropped || got.fault !== want.fault) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
                     want.read_value, want.held_count, want.dropped, want.fault,
                     got.read_value, got.held_count, got.dropped, got.fault);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int                      pick;
    logic [FuncWidth-1:0]    op;
    logic [ValueWidth-1:0]   word;
    logic [SizeWidth-1:0]    block_size;

    ring_size = SizeWidth'(DefaultDepth);
    ring_clear();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 66;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        size_write(directed_rows[i].cfg_size);
      else
        send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].slot,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // random blocks, four per idling phase, each under a fresh size
    for (int b = 0; b < NumBlocks; b++) begin
      case (b / 4)
        0: begin send_idle_pct = 35; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 35; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (b % 4)
        0: block_size = SizeWidth'(DefaultDepth);
        1: block_size = SizeWidth'($urandom_range(1, 3));
        2: block_size = SizeWidth'($urandom_range(1, DefaultDepth));
        default: block_size = SizeWidth'($urandom_range(4, DefaultDepth - 1));
      endcase
      size_write(block_size);
      for (int i = 0; i < BlockItems; i++) begin
        // hold off once until the result side has caught up
        if (b == 5 && i == BlockItems / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 30) op = FuncPushBack;
        else if (pick < 50) op = FuncPushFront;
        else if (pick < 64) op = FuncPopBack;
        else if (pick < 78) op = FuncPopFront;
        else if (pick < 97) op = FuncReadSlot;
        else op = FuncWidth'($urandom_range(FuncFirstUnused, FuncLastUnused));
        pick = $urandom_range(0, 99);
        if (pick < 4) word = 32'h80000000;
        else if (pick < 8) word = 32'h7fffffff;
        else word = $urandom();
        send_item(op, word, SlotIndexWidth'($urandom_range(0, DefaultDepth - 1)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
